[rtl/core/event_key_duplicate_filter_macros.svh]
// Assertion macros used by the duplicate filter tally module.
`ifndef EVENT_KEY_DUPLICATE_FILTER_MACROS_SVH
`define EVENT_KEY_DUPLICATE_FILTER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk and disabled during reset.
`define EKDF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("duplicate filter assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define EKDF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("duplicate filter assertion failed");

`else

`define EKDF_ASSERT_IMP(lbl, ante, cons)
`define EKDF_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

[rtl/core/ekdf_pkg.sv]
// Package with the key, result and chain link types of the duplicate filter.
package ekdf_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int FILL_W      = $clog2(STORE_DEPTH + 1);
    localparam int KEYS_W      = 11;
    localparam int DUP_W       = 32;
    localparam logic [DUP_W-1:0] DUP_MAX = '1;

    typedef struct packed {
        logic [31:0] run_number;
        logic [31:0] lumi_section;
        logic [63:0] event_number;
    } key_t;

    typedef struct packed {
        logic              keep;
        logic [DUP_W-1:0]  duplicates_seen;
        logic              store_full;
        logic [KEYS_W-1:0] keys_stored;
    } result_t;

    // What travels from one cell to the next along with an item.
    typedef struct packed {
        logic valid;
        key_t key;
        logic matched;
        logic inserted;
    } chain_t;

endpackage

[rtl/core/event_key_duplicate_filter.sv]
// Top level of the event key duplicate filter: a chain of key cells and a tally stage.
//
// Usage: present an event key on key and raise start; the item is taken at every
// rising edge where start is high and busy is low. busy stays low, so a new item
// may be offered in every cycle. Each item produces exactly one result, shown on
// result for one cycle with done high; the receiver cannot stall it.
// An item passes the register of every cell and then the result register of the tally.
// Throughput is one item per cycle, set by the one-register hop an item makes from
// each cell to the next.
// Each cell holds one stored key and a valid bit. An item walks down the chain one
// cell per cycle; every valid cell compares it with its key, and the first empty
// cell claims a key that no cell has matched. Because the chain fills in order and
// items keep their spacing, a following item always reaches a cell after any earlier
// item has written it. When every cell is full a new key passes through unclaimed:
// it is still kept, and store_full reads one.
// Reset clears all cell valid bits, the items in flight and both counters at once;
// no clearing pass is needed and the block takes items right after reset.
module event_key_duplicate_filter
    import ekdf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  key_t    key,
    output logic    done,
    output result_t result
);

    // link[i] feeds cell i; link[STORE_DEPTH] is the output of the last cell.
    chain_t link [STORE_DEPTH+1];

    // The chain never refuses an item.
    assign busy = 1'b0;

    always_comb
    begin
        link[0].valid    = start && !busy;
        link[0].key      = key;
        link[0].matched  = 1'b0;
        link[0].inserted = 1'b0;
    end

    for (genvar i = 0; i < STORE_DEPTH; i++)
    begin : g_cell
        ekdf_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .up    (link[i]),
            .down  (link[i+1])
        );
    end

    // The tally stage turns the match and claim flags into counters and the result.
    ekdf_tally u_tally (
        .clk    (clk),
        .rst_n  (rst_n),
        .last   (link[STORE_DEPTH]),
        .done   (done),
        .result (result)
    );

endmodule

[rtl/core/ekdf_cell.sv]
// One store cell: holds one key, compares the passing item and claims it if empty.
module ekdf_cell
    import ekdf_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  chain_t up,
    output chain_t down
);

    logic   entry_valid_reg;
    logic   entry_valid_next;
    key_t   entry_key_reg;
    logic   down_valid_reg;
    chain_t down_reg;
    chain_t down_next;
    logic   hit;
    logic   take;

    always_comb
    begin
        hit  = up.valid && entry_valid_reg && (entry_key_reg == up.key);
        take = up.valid && !entry_valid_reg && !up.matched && !up.inserted;

        entry_valid_next   = entry_valid_reg || take;
        down_next.valid    = up.valid;
        down_next.key      = up.key;
        down_next.matched  = up.matched || hit;
        down_next.inserted = up.inserted || take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
            down_valid_reg  <= 1'b0;
        end
        else
        begin
            entry_valid_reg <= entry_valid_next;
            down_valid_reg  <= down_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        down_reg <= down_next;
        if (take)
        begin
            entry_key_reg <= up.key;
        end
    end

    always_comb
    begin
        down       = down_reg;
        down.valid = down_valid_reg;
    end

endmodule

[rtl/core/ekdf_tally.sv]
// End of the chain: duplicate and fill counters and the registered result.
`include "event_key_duplicate_filter_macros.svh"

module ekdf_tally
    import ekdf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  chain_t  last,
    output logic    done,
    output result_t result
);

    logic [DUP_W-1:0]  dup_reg;
    logic [DUP_W-1:0]  dup_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              done_reg;
    result_t           result_reg;
    result_t           result_next;

    always_comb
    begin
        dup_next  = dup_reg;
        fill_next = fill_reg;
        if (last.valid)
        begin
            if (last.matched && (dup_reg != DUP_MAX))
            begin
                dup_next = dup_reg + DUP_W'(1);
            end
            if (last.inserted)
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end

        result_next.keep            = !last.matched;
        result_next.duplicates_seen = dup_next;
        result_next.store_full      = (fill_next >= FILL_W'(STORE_DEPTH));
        result_next.keys_stored     = KEYS_W'(fill_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dup_reg  <= '0;
            fill_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            dup_reg  <= dup_next;
            fill_reg <= fill_next;
            done_reg <= last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (last.valid)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // A key is never both found in some cell and claimed by one.
    `EKDF_ASSERT_IMP(a_match_xor_insert, last.valid, !(last.matched && last.inserted))
    // Cells can never hand out more entries than exist.
    `EKDF_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= FILL_W'(STORE_DEPTH))
    // Once every cell holds a key, no item can claim another one.
    `EKDF_ASSERT_IMP(a_full_no_insert, last.valid && (fill_reg == FILL_W'(STORE_DEPTH)),
                     !last.inserted)
    // The duplicate count only grows.
    `EKDF_ASSERT_NXT(a_dup_monotonic, 1'b1, dup_reg >= $past(dup_reg))

endmodule

[tb/event_key_duplicate_filter_test.sv]
// Self-checking testbench for the event key duplicate filter.
`timescale 1ns / 1ps

module event_key_duplicate_filter_test;
    import ekdf_pkg::*;

    // A key seen as one flat vector, so that it can index the set of recorded keys.
    typedef bit [$bits(key_t)-1:0] key_bits_t;

    // The tracker mirrors the block. It keeps the set of recorded keys, the fill
    // level and the saturating duplicate tally. For every accepted item it queues
    // the verdict that the block must give. Results come back in order, one per item,
    // so each result is checked against the oldest verdict in the queue.
    class seen_key_tracker;
        bit               recorded[key_bits_t];
        int unsigned      fill_level;
        logic [DUP_W-1:0] dup_tally;
        result_t          expected_verdicts[$];
        int unsigned      mismatches;

        function new();
            fill_level = 0;
            dup_tally  = '0;
            mismatches = 0;
        endfunction

        function void note_key(key_t k);
            result_t   verdict;
            key_bits_t kb;
            kb = key_bits_t'(k);
            if (recorded.exists(kb)) begin
                verdict.keep = 1'b0;
                if (dup_tally != DUP_MAX)
                    dup_tally++;
            end
            else begin
                // A new key is always kept. It is recorded only while a free
                // entry is left, so once the store is full a repeat of it is kept too.
                verdict.keep = 1'b1;
                if (fill_level < STORE_DEPTH) begin
                    recorded[kb] = 1'b1;
                    fill_level++;
                end
            end
            verdict.duplicates_seen = dup_tally;
            verdict.store_full      = (fill_level >= STORE_DEPTH);
            verdict.keys_stored     = KEYS_W'(fill_level);
            expected_verdicts = {expected_verdicts, verdict};
        endfunction

        function void log_mismatch(string why, result_t want, result_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s: expected keep=%0b dup=%0d full=%0b stored=%0d,",
                         $time, why, want.keep, want.duplicates_seen, want.store_full,
                         want.keys_stored,
                         " got keep=%0b dup=%0d full=%0b stored=%0d",
                         got.keep, got.duplicates_seen, got.store_full, got.keys_stored);
        endfunction

        function void check_verdict(result_t got);
            result_t want;
            if (expected_verdicts.size() == 0) begin
                log_mismatch("result with no item outstanding", '0, got);
                return;
            end
            want = expected_verdicts.pop_front();
            if (got.keep !== want.keep || got.duplicates_seen !== want.duplicates_seen ||
                got.store_full !== want.store_full || got.keys_stored !== want.keys_stored)
                log_mismatch("wrong result", want, got);
        endfunction

        function int unsigned outstanding();
            return expected_verdicts.size();
        endfunction

        // Any verdict still queued at the end belongs to an item whose result never came.
        function void flush_leftovers();
            while (expected_verdicts.size() != 0)
                log_mismatch("missing result", expected_verdicts.pop_front(), '0);
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    key_t    key;
    logic    done;
    result_t result;

    seen_key_tracker tracker = new();

    // Every key offered so far; repeats and near misses are drawn from it.
    key_t        sent_keys[$];
    // Chance in a hundred that the sender stays idle for another cycle.
    int unsigned idle_pct;

    event_key_duplicate_filter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .key    (key),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The monitor samples at the rising edge, before the block's registers move,
    // so it sees exactly what the block sees. The result is checked before the
    // new item is noted: the block can never answer an item at the edge that takes it.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (done !== 1'b0)
                tracker.check_verdict(result);
            if (start === 1'b1 && busy === 1'b0)
                tracker.note_key(key);
        end
    end

    // A random key. Each field is now and then forced to all zeros or all ones,
    // so that keys that share some fields and differ in others turn up often.
    function automatic key_t fresh_key();
        key_t k;
        k.run_number   = $urandom;
        k.lumi_section = $urandom;
        k.event_number = {$urandom, $urandom};
        case ($urandom_range(7))
            0: k.run_number = '0;
            1: k.run_number = '1;
            default: ;
        endcase
        case ($urandom_range(7))
            0: k.lumi_section = '0;
            1: k.lumi_section = '1;
            default: ;
        endcase
        case ($urandom_range(7))
            0: k.event_number = '0;
            1: k.event_number = '1;
            default: ;
        endcase
        return k;
    endfunction

    function automatic key_t replay_key();
        return sent_keys[$urandom_range(sent_keys.size() - 1)];
    endfunction

    // Offers one item and returns at the edge that takes it. Any idle gap comes
    // first, with start low and a junk key on the bus, so that start is lowered
    // and raised in different time steps. start is left high on return, which
    // lets the next item follow in the very next cycle.
    task automatic send_key(input key_t k);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            key   <= fresh_key();
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        start <= 1'b1;
        key   <= k;
        sent_keys = {sent_keys, k};
        do @(posedge clk); while (busy !== 1'b0);
    endtask

    // Holds the sender off until every item in flight has been answered.
    // The task waits on the clock before it returns, so start is never lowered and raised in one step.
    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge clk); while (tracker.outstanding() != 0);
    endtask

    // Short directed sequence: the extreme keys, back-to-back duplicates, keys that
    // differ from a stored key in a single bit of one field, and a duplicate count
    // that climbs past one.
    task automatic run_directed();
        key_t zero_key;
        key_t ones_key;
        key_t probe;
        zero_key = '0;
        ones_key = '1;
        idle_pct = 0;
        send_key(zero_key);
        send_key(zero_key);
        send_key(ones_key);
        send_key(ones_key);
        probe = zero_key;
        probe.run_number[0] = 1'b1;
        send_key(probe);
        probe = zero_key;
        probe.lumi_section[31] = 1'b1;
        send_key(probe);
        probe = zero_key;
        probe.event_number[63] = 1'b1;
        send_key(probe);
        probe = ones_key;
        probe.event_number[0] = 1'b0;
        send_key(probe);
        probe = zero_key;
        probe.run_number = '1;
        send_key(probe);
        probe = zero_key;
        probe.lumi_section = '1;
        send_key(probe);
        probe = zero_key;
        probe.event_number = '1;
        send_key(probe);
        send_key(zero_key);
        probe = ones_key;
        probe.event_number[0] = 1'b0;
        send_key(probe);
        // Repeats of stored keys and a fresh key sent twice, now with gaps between the items.
        idle_pct = 65;
        send_key(ones_key);
        probe = fresh_key();
        send_key(probe);
        send_key(probe);
        send_key(zero_key);
    endtask

    // Random items: repeats of earlier keys, near misses one bit away from an
    // earlier key, and fresh keys.
    task automatic run_random(input int unsigned count, input int unsigned pct);
        key_t        k;
        key_bits_t   kb;
        int unsigned roll;
        bit [6:0]    bitpos;
        idle_pct = pct;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 45) begin
                k = replay_key();
            end
            else if (roll < 60) begin
                kb = key_bits_t'(replay_key());
                bitpos = 7'($urandom_range($bits(key_t) - 1));
                kb[bitpos] = ~kb[bitpos];
                k = key_t'(kb);
            end
            else begin
                k = fresh_key();
            end
            send_key(k);
        end
    endtask

    // Fills every store entry, then offers new keys that find no free entry.
    // Those are kept but not recorded, so offering them again keeps them again,
    // while repeats of recorded keys are still dropped.
    task automatic fill_store();
        key_t unrecorded[$];
        key_t k;
        idle_pct = 0;
        while (tracker.fill_level < STORE_DEPTH)
            send_key(fresh_key());
        repeat (6) begin
            k = fresh_key();
            unrecorded = {unrecorded, k};
            send_key(k);
        end
        foreach (unrecorded[i])
            send_key(unrecorded[i]);
        repeat (6)
            send_key(replay_key());
    endtask

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        key      = '0;
        idle_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // Idling phases: none, a sender that is idle most of the time, and one
        // that is idle now and then.
        run_random(100, 0);
        run_random(100, 65);
        run_random(80, 8);

        // Let the whole chain empty before going on.
        wait_for_results();

        fill_store();
        run_random(100, 8);
        run_random(40, 65);

        // Results pass the register of every cell and the tally. After the last one, wait
        // longer than the chain takes to answer, so that any stray result is caught.
        wait_for_results();
        repeat (STORE_DEPTH + 32) @(posedge clk);
        tracker.flush_leftovers();

        if (tracker.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // This timeout lies far beyond the length of the whole run.
    initial
    begin
        #3_200_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/ekdf_pkg.sv
rtl/core/ekdf_cell.sv
rtl/core/ekdf_tally.sv
rtl/core/event_key_duplicate_filter.sv
tb/event_key_duplicate_filter_test.sv
